/* sv/cht_pkg.sv */
// Shared types, codes and defaults for the cuckoo hash table.
package cht_pkg;

  localparam int DEF_TABLE_SIZE = 16;
  localparam int DEF_KEY_WIDTH  = 32;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int KEY_W    = 32;
  localparam int KICK_W   = 7;

  localparam logic [KICK_W-1:0] MAX_KICKS_RESET = 7'd24;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHK1,
    S_CHK2,
    S_ICHK,
    S_RESP
  } ctl_state_t;

endpackage

/* sv/cht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cht_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/cht_hash.sv */
// Hash unit: both candidate slots of a key, registered directly for power-of-two
// tables, a reciprocal-multiply pipeline otherwise.
module cht_hash import cht_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int KW         = DEF_KEY_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [KW-1:0]                 key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] h1,
  output logic [$clog2(TABLE_SIZE)-1:0] h2
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int NW    = IDX_W + 1;
  localparam int EXT_W = (KW > IDX_W) ? KW : NW;
  localparam int PW    = 2 * IDX_W;

  logic [EXT_W-1:0] key_ext;
  assign key_ext = EXT_W'(key);

  generate
    if ((1 << IDX_W) == TABLE_SIZE) begin : g_pow2
      logic [IDX_W-1:0] a, b, p;
      logic             done_r;
      logic [IDX_W-1:0] h1_r, h2_r;

      assign a = key_ext[IDX_W-1:0];
      // mod by a power of two is truncation at every step
      assign b = a + IDX_W'(3);
      assign p = a * b;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          h1_r <= a;
          h2_r <= p;
        end
      end

      assign done = done_r;
      assign h1   = h1_r;
      assign h2   = h2_r;
    end else begin : g_recip
      // floor(x * M / 2^s) with M = floor(2^s / N) is x / N or one less for
      // x < 2^s, so a single compare and subtract finishes each remainder
      localparam logic [KW-1:0] M1 = KW'((64'd1 << KW) / TABLE_SIZE);
      localparam logic [PW-1:0] M2 = PW'((64'd1 << PW) / TABLE_SIZE);
      localparam logic [NW-1:0] NN = NW'(TABLE_SIZE);

      logic [4:0]       stg_r;
      logic             done_r;
      logic [EXT_W-1:0] key_r, q1_r;
      logic [IDX_W-1:0] h1_r, b_r, h2_r;
      logic [PW-1:0]    p_r, q2_r;
      logic [2*KW-1:0]  prod1;
      logic [2*PW-1:0]  prod2;
      logic [NW-1:0]    r1, r1_red, bsum, bred, r2, r2_red;

      always_comb begin
        prod1  = (2*KW)'(key) * (2*KW)'(M1);
        r1     = key_r[NW-1:0] - NW'(q1_r[NW-1:0] * NN);
        r1_red = (r1 >= NN) ? r1 - NN : r1;
        bsum   = {1'b0, h1_r} + NW'(3);
        bred   = (bsum >= NN) ? bsum - NN : bsum;
        prod2  = (2*PW)'(p_r) * (2*PW)'(M2);
        r2     = p_r[NW-1:0] - NW'(q2_r[NW-1:0] * NN);
        r2_red = (r2 >= NN) ? r2 - NN : r2;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_r  <= '0;
          done_r <= 1'b0;
        end else begin
          stg_r  <= {stg_r[3:0], start};
          done_r <= stg_r[4];
        end
        if (start) begin
          key_r <= key_ext;
          q1_r  <= EXT_W'(prod1[2*KW-1:KW]);
        end
        if (stg_r[0]) h1_r <= r1_red[IDX_W-1:0];
        if (stg_r[1]) b_r  <= bred[IDX_W-1:0];
        if (stg_r[2]) p_r  <= PW'(h1_r) * PW'(b_r);
        if (stg_r[3]) q2_r <= prod2[2*PW-1:PW];
        if (stg_r[4]) h2_r <= r2_red[IDX_W-1:0];
      end

      assign done = done_r;
      assign h1   = h1_r;
      assign h2   = h2_r;
    end
  endgenerate

endmodule

/* sv/cuckoo_hash_table.sv */
// Cuckoo hash table top level: control sequencer around the slot RAM.
//
// Input channel (in_valid/in_ready, in_mode, in_key) takes one operation per
// transaction: insert, delete or search. Each transaction yields exactly one
// result transaction on out_valid/out_ready (out_status, out_position,
// out_dropped_key). max_kicks is written through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Operations run one at a time. A search or delete hashes the key, then reads
// the first candidate slot and, on a miss, the second; an insert fills an
// empty slot or evicts the occupant and rehashes it; unused mode codes answer
// without a hash. Each step waits on the registered read of the slot RAM; for
// non-power-of-two table sizes each hash is a reciprocal-multiply pipeline.
// Reset clears the valid bits by a sweep over all TABLE_SIZE slots, one slot per
// cycle; in_ready stays low meanwhile, configuration writes still land.
// The result sits in an output register: a new operation is accepted while
// it waits, and a finished operation holds in its response step until the
// register is free.
module cuckoo_hash_table import cht_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE,
  parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [MODE_W-1:0]             in_mode,
  input  logic [KEY_W-1:0]              in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [STATUS_W-1:0]           out_status,
  output logic [$clog2(TABLE_SIZE)-1:0] out_position,
  output logic [KEY_W-1:0]              out_dropped_key,
  input  logic                          cfg_we,
  input  logic [KICK_W-1:0]             cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int KW    = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
  localparam int MW    = KW + 1;

  ctl_state_t          state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [KICK_W-1:0]   kick_r, kick_nxt;
  logic [KICK_W-1:0]   max_kicks_r;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_pos_r, res_pos_nxt;
  logic [KEY_W-1:0]    res_drop_r, res_drop_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_position_r;
  logic [KEY_W-1:0]    out_dropped_key_r;

  logic                out_free, out_load;
  logic                hash_start, hash_done;
  logic [KW-1:0]       hash_key;
  logic [IDX_W-1:0]    h1, h2;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr, walk_pos;
  logic [MW-1:0]       mem_wdata, mem_rdata;
  logic                rd_valid, hit;
  logic [KW-1:0]       rd_key;

  assign out_free = !out_valid_r || out_ready;
  assign rd_valid = mem_rdata[KW];
  assign rd_key   = mem_rdata[KW-1:0];
  assign hit      = rd_valid && (rd_key == key_r);
  // an evicted key moves to whichever of its candidates it was not sitting in
  assign walk_pos = (kick_r == '0) ? h1 : ((h1 == pos_r) ? h2 : h1);

  cht_hash #(
    .TABLE_SIZE(TABLE_SIZE),
    .KW        (KW)
  ) u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hash_start),
    .key  (hash_key),
    .done (hash_done),
    .h1   (h1),
    .h2   (h2)
  );

  cht_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_SIZE)
  ) u_slots (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == IDX_W'(TABLE_SIZE - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode) inside
            MODE_INSERT, MODE_DELETE, MODE_SEARCH: state_nxt = S_HASH;
            default:                               state_nxt = S_RESP;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) state_nxt = (mode_r == MODE_INSERT) ? S_ICHK : S_CHK1;
      end
      S_CHK1: state_nxt = hit ? S_RESP : S_CHK2;
      S_CHK2: state_nxt = S_RESP;
      S_ICHK: begin
        if (!rd_valid || (kick_r >= max_kicks_r)) state_nxt = S_RESP;
        else                                     state_nxt = S_HASH;
      end
      S_RESP: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    hash_start     = 1'b0;
    hash_key       = KW'(in_key);
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = {1'b1, key_r};
    mem_raddr      = h1;
    out_load       = 1'b0;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    kick_nxt       = kick_r;
    clr_cnt_nxt    = clr_cnt_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_drop_nxt   = res_drop_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt       = in_mode;
          key_nxt        = KW'(in_key);
          kick_nxt       = '0;
          res_status_nxt = ST_NOTFOUND;
          res_pos_nxt    = '0;
          res_drop_nxt   = '0;
          case (in_mode) inside
            MODE_INSERT, MODE_DELETE, MODE_SEARCH: hash_start = 1'b1;
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (mode_r == MODE_INSERT) begin
          mem_raddr = walk_pos;
          if (hash_done) begin
            pos_nxt = walk_pos;
            if (kick_r == '0) res_pos_nxt = h1;
          end
        end
      end
      S_CHK1: begin
        mem_raddr = h2;
        if (hit) begin
          res_pos_nxt = h1;
          if (mode_r == MODE_DELETE) begin
            mem_we         = 1'b1;
            mem_waddr      = h1;
            mem_wdata      = {1'b0, rd_key};
            res_status_nxt = ST_DELETED;
          end else begin
            res_status_nxt = ST_FOUND;
          end
        end
      end
      S_CHK2: begin
        if (hit) begin
          res_pos_nxt = h2;
          if (mode_r == MODE_DELETE) begin
            mem_we         = 1'b1;
            mem_waddr      = h2;
            mem_wdata      = {1'b0, rd_key};
            res_status_nxt = ST_DELETED;
          end else begin
            res_status_nxt = ST_FOUND;
          end
        end
      end
      S_ICHK: begin
        if (!rd_valid) begin
          mem_we         = 1'b1;
          res_status_nxt = ST_INSERTED;
        end else if (kick_r >= max_kicks_r) begin
          res_status_nxt = ST_FAILED;
          res_drop_nxt   = KEY_W'(key_r);
        end else begin
          // place the carried key, pick up the occupant and rehash it
          mem_we     = 1'b1;
          key_nxt    = rd_key;
          kick_nxt   = kick_r + KICK_W'(1);
          hash_start = 1'b1;
          hash_key   = rd_key;
        end
      end
      S_RESP: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      kick_r      <= '0;
      max_kicks_r <= MAX_KICKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      kick_r    <= kick_nxt;
      if (cfg_we) max_kicks_r <= cfg_wdata;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_drop_r   <= res_drop_nxt;
    if (out_load) begin
      out_status_r      <= res_status_r;
      out_position_r    <= res_pos_r;
      out_dropped_key_r <= res_drop_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_dropped_key = out_dropped_key_r;

endmodule

/* sv/cht_checker.sv */
// Port-level assertions for the cuckoo hash table, bound to the top level.
module cht_checker import cht_pkg::*; #(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [STATUS_W-1:0]           out_status,
  input logic [$clog2(TABLE_SIZE)-1:0] out_position,
  input logic [KEY_W-1:0]              out_dropped_key
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_position) && $stable(out_dropped_key))
    else $error("result changed while stalled");

  // one operation in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted back to back");

  // a fresh result is released only as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while an operation was busy");

  // only a failed insert reports a dropped key; a miss reports slot zero
  a_drop_only_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FAILED) |-> (out_dropped_key == '0)
      && ((out_status != ST_NOTFOUND) || (out_position == '0)))
    else $error("dropped key or position set on wrong status");

endmodule

bind cuckoo_hash_table cht_checker #(.TABLE_SIZE(TABLE_SIZE)) u_cht_checker (.*);
